// File: hw/rtl/forward_moving_average_unit_macros.svh
// Assertion macros for the forward moving average unit.
// Uses aclk and aresetn of the module that includes this header.
`ifndef FORWARD_MOVING_AVERAGE_UNIT_MACROS_SVH
`define FORWARD_MOVING_AVERAGE_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FMA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition is followed by another one on the next edge.
`define FMA_ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (nxt)) \
        else $error(msg);

`endif

// File: hw/rtl/fma_pkg.sv
// Shared constants and controller/datapath interface types of the
// forward moving average unit. No dependencies.
package fma_pkg;

    localparam int MAX_WINDOW  = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int WIN_BITS    = 6;
    localparam int PTR_BITS    = $clog2(MAX_WINDOW);
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
    localparam int MAG_BITS    = SUM_BITS - 1;
    localparam int DIV_CNT_BITS = $clog2(MAG_BITS + 1);
    localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(4);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;       // latch sample, read old ring slot, write new one
        logic update;       // update running sum, pointer, count and tail count
        logic div_start;    // start division of the running sum
        logic load_avg;     // load the quotient into the output register
        logic load_zero;    // load one tail zero into the output register
        logic clear_array;  // clear array state after the final result
    } fma_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic full;         // seen count equals the window
        logic last;         // latched sample closes the array
        logic has_zeros;    // tail zeros remain
        logic zero_final;   // exactly one tail zero remains
        logic div_done;     // quotient is ready
        logic out_free;     // output register can take a transfer
    } fma_status_t;

endpackage

// File: hw/rtl/forward_moving_average_unit.sv
// Forward moving average over a stream of Q1.15 samples framed by a last flag.
// Channels: s_ (sample, last_sample) in, m_ (average, last_result) out,
// both valid/ready; a transfer happens when valid and ready are high.
// Configuration: cfg_wr_en/cfg_wr_data set the window (0 acts as 1, values
// above 32 act as 32) and start a new array; write only while idle.
// Each array gives one result per sample: result i is the mean of samples
// i..i+W-1, truncated toward zero; the last sample adds W-1 zero results
// (or one per sample for arrays shorter than W), the final one flagged.
// Sequence, with m_ready high: a sample that completes a window raises m_valid
// and s_ready after the sum update, the check, 21 divider steps, the divider's
// done flag and the output load; s_ready stays low until then. Other samples
// pass the sum update and the check; a last one goes on to the tail zeros.
// Tail zeros go out one per cycle while m_ready stays high.
// The output register lets a new sample be taken while a result waits;
// a stalled receiver holds m_ valid and data and stops further results.
// Reset (aresetn low, synchronous) sets the window to 4, clears the running
// sum, count and pointer, and empties the output register.
// Depends on fma_pkg, fma_ctrl, fma_dp and fma_div.
module forward_moving_average_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [fma_pkg::WIN_BITS-1:0]           cfg_wr_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [fma_pkg::SAMPLE_BITS-1:0] s_sample,
    input  logic                                   s_last_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [fma_pkg::SAMPLE_BITS-1:0] m_average,
    output logic                                   m_last_result
);
    import fma_pkg::*;

    fma_cmd_t    cmd;
    fma_status_t status;

    fma_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fma_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_sample      (s_sample),
        .s_last_sample (s_last_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_average     (m_average),
        .m_last_result (m_last_result),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

// File: hw/rtl/fma_div.sv
// Restoring divider, one quotient bit per cycle: magnitude over window.
// Depends on fma_pkg.
module fma_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [fma_pkg::MAG_BITS-1:0]  dividend,
    input  logic [fma_pkg::WIN_BITS-1:0]  divisor,
    output logic                          done,
    output logic [fma_pkg::MAG_BITS-1:0]  quotient
);
    import fma_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [WIN_BITS-1:0]     rem_reg, rem_next;
    logic [MAG_BITS-1:0]     quo_reg, quo_next;
    logic [WIN_BITS:0]       trial;

    // Shift in one dividend bit and try a subtract
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, quo_reg[MAG_BITS-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_BITS'(MAG_BITS);
            rem_next  = '0;
            quo_next  = dividend;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = WIN_BITS'(trial - {1'b0, divisor});
                quo_next = {quo_reg[MAG_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial[WIN_BITS-1:0];
                quo_next = {quo_reg[MAG_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hw/rtl/fma_ctrl.sv
// Controller state machine: sequences accept, sum update, division and
// result transfers. Depends on fma_pkg and the assertion macro header.
`include "forward_moving_average_unit_macros.svh"

module fma_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  fma_pkg::fma_status_t status,
    output fma_pkg::fma_cmd_t    cmd
);
    import fma_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_CHECK,
        ST_DIV,
        ST_AVG,
        ST_TAIL
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && ready_reg) begin
                    cmd.accept = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.full) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else if (status.last) begin
                    state_next = ST_TAIL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG: begin
                if (status.out_free) begin
                    cmd.load_avg = 1'b1;
                    if (status.last && status.has_zeros) begin
                        state_next = ST_TAIL;
                    end else begin
                        cmd.clear_array = status.last;
                        state_next      = ST_IDLE;
                    end
                end
            end
            ST_TAIL: begin
                if (status.out_free) begin
                    cmd.load_zero = 1'b1;
                    if (status.zero_final) begin
                        cmd.clear_array = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_ready = ready_reg;

    `FMA_ASSERT(a_ready_idle, !ready_reg || state_reg == ST_IDLE, "ready outside idle")
    `FMA_ASSERT_NEXT(a_accept_sum, s_valid && ready_reg, state_reg == ST_SUM,
        "transfer did not start a sum update")
    `FMA_ASSERT(a_done_in_div, !status.div_done || state_reg == ST_DIV,
        "quotient ready outside division")

endmodule

// File: hw/rtl/fma_dp.sv
// Datapath: sample ring, running sum, counters, divider and output register.
// Depends on fma_pkg and fma_div.
module fma_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [fma_pkg::WIN_BITS-1:0]         cfg_wr_data,
    input  logic signed [fma_pkg::SAMPLE_BITS-1:0] s_sample,
    input  logic                                 s_last_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [fma_pkg::SAMPLE_BITS-1:0] m_average,
    output logic                                 m_last_result,
    input  fma_pkg::fma_cmd_t                    cmd,
    output fma_pkg::fma_status_t                 status
);
    import fma_pkg::*;

    logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] old_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          last_reg;

    logic [WIN_BITS-1:0]        win_reg, win_next;
    logic signed [SUM_BITS-1:0] sum_reg, sum_next;
    logic [WIN_BITS-1:0]        seen_reg, seen_next;
    logic [PTR_BITS-1:0]        ptr_reg, ptr_next;
    logic [WIN_BITS-1:0]        zeros_reg, zeros_next;
    logic                       neg_reg;

    logic                          m_valid_reg, m_valid_next;
    logic signed [SAMPLE_BITS-1:0] avg_reg;
    logic                          last_out_reg;

    logic [WIN_BITS:0]          ptr_ext;
    logic [WIN_BITS:0]          old_ext;
    logic [PTR_BITS-1:0]        old_addr;
    logic [WIN_BITS-1:0]        win_eff;
    logic [WIN_BITS-1:0]        seen_inc;
    logic signed [SUM_BITS-1:0] sum_abs;
    logic [MAG_BITS-1:0]        quotient;
    logic [MAG_BITS-1:0]        quo_signed;
    logic                       div_done;
    logic                       out_free;

    // Slot of the sample that leaves the window
    assign ptr_ext  = (WIN_BITS + 1)'(ptr_reg);
    assign old_ext  = (ptr_ext >= {1'b0, win_reg})
                    ? ptr_ext - {1'b0, win_reg}
                    : ptr_ext + (WIN_BITS + 1)'(MAX_WINDOW) - {1'b0, win_reg};
    assign old_addr = old_ext[PTR_BITS-1:0];

    // Clamp the written window to one through the ring depth
    always_comb begin
        if (cfg_wr_data == '0) begin
            win_eff = WIN_BITS'(1);
        end else if (cfg_wr_data > WIN_BITS'(MAX_WINDOW)) begin
            win_eff = WIN_BITS'(MAX_WINDOW);
        end else begin
            win_eff = cfg_wr_data;
        end
    end

    // Ring write and registered read of the leaving sample
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            ring[ptr_reg] <= s_sample;
            old_reg       <= ring[old_addr];
            sample_reg    <= s_sample;
            last_reg      <= s_last_sample;
        end
    end

    // Update sum, pointer, count and tail count
    always_comb begin
        win_next   = win_reg;
        sum_next   = sum_reg;
        seen_next  = seen_reg;
        ptr_next   = ptr_reg;
        zeros_next = zeros_reg;
        seen_inc   = (seen_reg < win_reg) ? seen_reg + 1'b1 : seen_reg;
        if (cmd.update) begin
            if (seen_reg >= win_reg) begin
                sum_next = sum_reg - SUM_BITS'(old_reg) + SUM_BITS'(sample_reg);
            end else begin
                sum_next = sum_reg + SUM_BITS'(sample_reg);
            end
            seen_next = seen_inc;
            ptr_next  = (ptr_reg == PTR_BITS'(MAX_WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
            if (!last_reg) begin
                zeros_next = '0;
            end else if (seen_inc == win_reg) begin
                zeros_next = win_reg - 1'b1;
            end else begin
                zeros_next = seen_inc;
            end
        end
        if (cmd.load_zero) begin
            zeros_next = zeros_reg - 1'b1;
        end
        if (cmd.clear_array) begin
            sum_next  = '0;
            seen_next = '0;
            ptr_next  = '0;
        end
        if (cfg_wr_en) begin
            win_next  = win_eff;
            sum_next  = '0;
            seen_next = '0;
            ptr_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   <= WINDOW_RESET;
            sum_reg   <= '0;
            seen_reg  <= '0;
            ptr_reg   <= '0;
            zeros_reg <= '0;
        end else begin
            win_reg   <= win_next;
            sum_reg   <= sum_next;
            seen_reg  <= seen_next;
            ptr_reg   <= ptr_next;
            zeros_reg <= zeros_next;
        end
    end

    // Divide the magnitude, restore the sign afterwards
    assign sum_abs = sum_reg[SUM_BITS-1] ? -sum_reg : sum_reg;

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            neg_reg <= sum_reg[SUM_BITS-1];
        end
    end

    fma_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_abs[MAG_BITS-1:0]),
        .divisor  (win_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign quo_signed = neg_reg ? -quotient : quotient;

    // Output register: load a result, drop it after the transfer
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_avg || cmd.load_zero) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (cmd.load_avg) begin
            avg_reg      <= quo_signed[SAMPLE_BITS-1:0];
            last_out_reg <= last_reg && (zeros_reg == '0);
        end else if (cmd.load_zero) begin
            avg_reg      <= '0;
            last_out_reg <= (zeros_reg == WIN_BITS'(1));
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_average     = avg_reg;
    assign m_last_result = last_out_reg;

    // Status for the controller
    always_comb begin
        status            = '0;
        status.full       = (seen_reg == win_reg);
        status.last       = last_reg;
        status.has_zeros  = (zeros_reg != '0);
        status.zero_final = (zeros_reg == WIN_BITS'(1));
        status.div_done   = div_done;
        status.out_free   = out_free;
    end

endmodule
